/* rtl/cubic_bezier_flatten_transform_core_assert.svh */
// Assertion macros for the Bezier flattening core checker.
`ifndef CUBIC_BEZIER_FLATTEN_TRANSFORM_CORE_ASSERT_SVH
`define CUBIC_BEZIER_FLATTEN_TRANSFORM_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CBF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cbf check failed");
// Next-cycle implication checked outside reset.
`define CBF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cbf check failed");
`endif

/* rtl/cbf_pkg.sv */
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared constants, types and arithmetic helpers of the Bezier flattener.
// ----------------------------------------------------------------------------
`default_nettype none
package cbf_pkg;
	localparam int MAX_DIVS_DEF  = 63;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DIV_W         = 6;
	localparam int IDX_W         = 3;

	localparam logic [IDX_W-1:0] REG_OFFSET_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_ANCHOR_X = 3'd2;
	localparam logic [IDX_W-1:0] REG_ANCHOR_Y = 3'd3;
	localparam logic [IDX_W-1:0] REG_SCALE_X  = 3'd4;
	localparam logic [IDX_W-1:0] REG_SCALE_Y  = 3'd5;
	localparam logic [IDX_W-1:0] REG_COS_ROT  = 3'd6;
	localparam logic [IDX_W-1:0] REG_SIN_ROT  = 3'd7;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [17:0] cr;
		logic signed [17:0] sr;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               last;
	} pt_t;

	// Saturate a 66-bit signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (v > hi) return 32'sh7fffffff;
		else if (v < lo) return 32'sh80000000;
		else return v[31:0];
	endfunction
endpackage
`default_nettype wire

/* rtl/cbf_param_gen.sv */
// ----------------------------------------------------------------------------
// cbf_param_gen
// Walks the run of one segment and issues t for each point, one per cycle while advance is high.
// t = floor(j*2^F/D) is kept as an integer part and a remainder, stepped by
// a precomputed quotient and remainder of 2^F/D taken from a small restoring
// division unit run before the walk.
// ----------------------------------------------------------------------------
`default_nettype none
module cbf_param_gen #(
	parameter int MAX_DIVS  = cbf_pkg::MAX_DIVS_DEF,
	parameter int FRAC_BITS = cbf_pkg::FRAC_BITS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [cbf_pkg::DIV_W-1:0]  divisions,
	input  wire                       final_segment,
	input  wire                       advance,
	output logic                      busy,
	output logic                      t_valid,
	output logic [FRAC_BITS:0]        t_val,
	output logic                      t_last
);
	localparam int DW = cbf_pkg::DIV_W;
	localparam int CW = $clog2(FRAC_BITS + 2);

	logic [DW-1:0]      divs_q;
	logic [DW:0]        count_q;
	logic [DW:0]        idx_q;
	logic [FRAC_BITS:0] quo_q;
	logic [DW-1:0]      rem_q;
	logic [FRAC_BITS:0] t_q;
	logic [DW-1:0]      tr_q;
	logic [CW-1:0]      bit_q;
	logic               div_q;
	logic               walk_q;
	logic [DW-1:0]      divs_c;
	logic [DW:0]        trial;
	logic [DW:0]        tr_next;

	always_comb begin
		divs_c = (divisions == '0) ? DW'(1) : divisions;
		if (int'(divs_c) > MAX_DIVS) divs_c = DW'(MAX_DIVS);
	end

	// One quotient bit of 2^F / D per cycle; dividend has a single one bit.
	assign trial   = {rem_q, (bit_q == CW'(FRAC_BITS))};
	assign tr_next = {1'b0, tr_q} + {1'b0, rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q   <= 1'b0;
			walk_q  <= 1'b0;
			idx_q   <= '0;
			count_q <= '0;
			bit_q   <= '0;
		end else if (start) begin
			div_q   <= 1'b1;
			walk_q  <= 1'b0;
			bit_q   <= CW'(FRAC_BITS);
			idx_q   <= '0;
			count_q <= {1'b0, divs_c} + (DW+1)'(final_segment);
		end else if (div_q) begin
			if (bit_q == '0) begin
				div_q  <= 1'b0;
				walk_q <= 1'b1;
			end else begin
				bit_q <= bit_q - CW'(1);
			end
		end else if (walk_q && advance) begin
			idx_q <= idx_q + (DW+1)'(1);
			if (idx_q + (DW+1)'(1) == count_q) walk_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divs_q <= divs_c;
			rem_q  <= '0;
			quo_q  <= '0;
			t_q    <= '0;
			tr_q   <= '0;
		end else if (div_q) begin
			if (trial >= {1'b0, divs_q}) begin
				rem_q <= DW'(trial - {1'b0, divs_q});
				quo_q <= {quo_q[FRAC_BITS-1:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[FRAC_BITS-1:0], 1'b0};
			end
		end else if (walk_q && advance) begin
			if (tr_next >= {1'b0, divs_q}) begin
				tr_q <= DW'(tr_next - {1'b0, divs_q});
				t_q  <= t_q + quo_q + (FRAC_BITS+1)'(1);
			end else begin
				tr_q <= tr_next[DW-1:0];
				t_q  <= t_q + quo_q;
			end
		end
	end

	assign busy    = div_q | walk_q;
	assign t_valid = walk_q;
	assign t_val   = t_q;
	assign t_last  = (idx_q + (DW+1)'(1) == count_q);
endmodule
`default_nettype wire

/* rtl/cbf_lerp_stage.sv */
// ----------------------------------------------------------------------------
// cbf_lerp_stage
// One registered level of de Casteljau: N-1 lerps of N points per axis, plus
// carried t, last flag and valid.
// ----------------------------------------------------------------------------
`default_nettype none
module cbf_lerp_stage #(
	parameter int N         = 4,
	parameter int FRAC_BITS = cbf_pkg::FRAC_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        en,
	input  wire                        in_valid,
	input  wire [FRAC_BITS:0]          in_t,
	input  wire                        in_last,
	input  wire signed [N*32-1:0]      in_px,
	input  wire signed [N*32-1:0]      in_py,
	output logic                       out_valid,
	output logic [FRAC_BITS:0]         out_t,
	output logic                       out_last,
	output logic signed [(N-1)*32-1:0] out_px,
	output logic signed [(N-1)*32-1:0] out_py
);
	localparam logic [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

	logic signed [FRAC_BITS+2:0] tw;
	logic signed [FRAC_BITS+2:0] uw;
	logic signed [(N-1)*32-1:0]  nx;
	logic signed [(N-1)*32-1:0]  ny;

	assign tw = $signed({2'b00, in_t});
	assign uw = $signed({1'b0, ONE}) - tw;

	always_comb begin
		for (int i = 0; i < N-1; i++) begin
			nx[i*32 +: 32] = cbf_pkg::sat32(66'((66'($signed(in_px[i*32 +: 32])) * uw
				+ 66'($signed(in_px[(i+1)*32 +: 32])) * tw) >>> FRAC_BITS));
			ny[i*32 +: 32] = cbf_pkg::sat32(66'((66'($signed(in_py[i*32 +: 32])) * uw
				+ 66'($signed(in_py[(i+1)*32 +: 32])) * tw) >>> FRAC_BITS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_t    <= in_t;
			out_last <= in_last;
			out_px   <= nx;
			out_py   <= ny;
		end
	end
endmodule
`default_nettype wire

/* rtl/cbf_xform.sv */
// ----------------------------------------------------------------------------
// cbf_xform
// Anchor, rotation, scale and offset in four register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module cbf_xform #(
	parameter int FRAC_BITS = cbf_pkg::FRAC_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  cbf_pkg::cfg_t       cfg,
	input  wire                 in_valid,
	input  cbf_pkg::pt_t        in_pt,
	output logic                out_valid,
	output cbf_pkg::pt_t        out_pt
);
	logic         v_s1, v_s2, v_s3, v_s4;
	cbf_pkg::pt_t a_s1, c_s3, o_s4;
	logic signed [65:0] xc_s2, xs_s2, yc_s2, ys_s2;
	logic               l_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1.x    <= cbf_pkg::sat32(66'(in_pt.x) - 66'(cfg.ax));
			a_s1.y    <= cbf_pkg::sat32(66'(in_pt.y) - 66'(cfg.ay));
			a_s1.last <= in_pt.last;
			xc_s2 <= 66'(a_s1.x) * 66'(cfg.cr);
			xs_s2 <= 66'(a_s1.x) * 66'(cfg.sr);
			yc_s2 <= 66'(a_s1.y) * 66'(cfg.cr);
			ys_s2 <= 66'(a_s1.y) * 66'(cfg.sr);
			l_s2  <= a_s1.last;
			c_s3.x    <= cbf_pkg::sat32((xc_s2 - ys_s2) >>> FRAC_BITS);
			c_s3.y    <= cbf_pkg::sat32((xs_s2 + yc_s2) >>> FRAC_BITS);
			c_s3.last <= l_s2;
			o_s4.x <= cbf_pkg::sat32(66'(cfg.ox) + 66'(cbf_pkg::sat32(
				(66'(c_s3.x) * 66'(cfg.sx)) >>> FRAC_BITS)));
			o_s4.y <= cbf_pkg::sat32(66'(cfg.oy) + 66'(cbf_pkg::sat32(
				(66'(c_s3.y) * 66'(cfg.sy)) >>> FRAC_BITS)));
			o_s4.last <= c_s3.last;
		end
	end

	assign out_valid = v_s4;
	assign out_pt    = o_s4;
endmodule
`default_nettype wire

/* rtl/cubic_bezier_flatten_transform_core.sv */
// The step division runs first after the input beat; then three lerp stages and
// four transform stages carry each point to the output.
// Throughput: one point per cycle while the output is not stalled; a segment of D
// divisions gives D points (D+1 for a final segment), walked by the t walker after
// its step division, and no new segment is taken until the walk ends.
// Reset clears all valid bits and restores the register reset values.
// ----------------------------------------------------------------------------
// cubic_bezier_flatten_transform_core
// Flattens one cubic Bezier segment per input beat into a run of transformed
// points, one output beat per point.
// ----------------------------------------------------------------------------
`default_nettype none
module cubic_bezier_flatten_transform_core #(
	parameter int MAX_DIVS  = cbf_pkg::MAX_DIVS_DEF,
	parameter int FRAC_BITS = cbf_pkg::FRAC_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire [2:0]         cfg_index,
	input  wire [31:0]        cfg_data,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire signed [31:0] p0_x,
	input  wire signed [31:0] p0_y,
	input  wire signed [31:0] p1_x,
	input  wire signed [31:0] p1_y,
	input  wire signed [31:0] p2_x,
	input  wire signed [31:0] p2_y,
	input  wire signed [31:0] p3_x,
	input  wire signed [31:0] p3_y,
	input  wire [5:0]         divisions,
	input  wire               final_segment,
	output logic              out_valid,
	input  wire               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic              run_last
);
	cbf_pkg::cfg_t cfg_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= '0;
			cfg_q.sx <= 32'sd65536;
			cfg_q.sy <= 32'sd65536;
			cfg_q.cr <= 18'sd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				cbf_pkg::REG_OFFSET_X: cfg_q.ox <= cfg_data;
				cbf_pkg::REG_OFFSET_Y: cfg_q.oy <= cfg_data;
				cbf_pkg::REG_ANCHOR_X: cfg_q.ax <= cfg_data;
				cbf_pkg::REG_ANCHOR_Y: cfg_q.ay <= cfg_data;
				cbf_pkg::REG_SCALE_X:  cfg_q.sx <= cfg_data;
				cbf_pkg::REG_SCALE_Y:  cfg_q.sy <= cfg_data;
				cbf_pkg::REG_COS_ROT:  cfg_q.cr <= cfg_data[17:0];
				cbf_pkg::REG_SIN_ROT:  cfg_q.sr <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// Held control points of the segment being walked.
	logic signed [127:0] hx_q, hy_q;
	logic busy, tv, tl, adv, en, accept;
	logic [FRAC_BITS:0] tval;

	// Whole pipeline moves together; it stalls only when the output is full.
	assign en       = !out_valid || out_ready;
	assign adv      = en;
	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			hx_q <= {p3_x, p2_x, p1_x, p0_x};
			hy_q <= {p3_y, p2_y, p1_y, p0_y};
		end
	end

	cbf_param_gen #(.MAX_DIVS(MAX_DIVS), .FRAC_BITS(FRAC_BITS)) u_gen (
		.clk(clk), .arst_n(arst_n), .start(accept), .divisions(divisions),
		.final_segment(final_segment), .advance(adv), .busy(busy),
		.t_valid(tv), .t_val(tval), .t_last(tl)
	);

	logic v1, v2, v3, l1, l2, l3;
	logic [FRAC_BITS:0] t1, t2, t3;
	logic signed [95:0] x1, y1;
	logic signed [63:0] x2, y2;
	logic signed [31:0] x3, y3;

	cbf_lerp_stage #(.N(4), .FRAC_BITS(FRAC_BITS)) u_l1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(tv), .in_t(tval),
		.in_last(tl), .in_px(hx_q), .in_py(hy_q), .out_valid(v1), .out_t(t1),
		.out_last(l1), .out_px(x1), .out_py(y1)
	);
	cbf_lerp_stage #(.N(3), .FRAC_BITS(FRAC_BITS)) u_l2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v1), .in_t(t1),
		.in_last(l1), .in_px(x1), .in_py(y1), .out_valid(v2), .out_t(t2),
		.out_last(l2), .out_px(x2), .out_py(y2)
	);
	cbf_lerp_stage #(.N(2), .FRAC_BITS(FRAC_BITS)) u_l3 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v2), .in_t(t2),
		.in_last(l2), .in_px(x2), .in_py(y2), .out_valid(v3), .out_t(t3),
		.out_last(l3), .out_px(x3), .out_py(y3)
	);

	cbf_pkg::pt_t pin, pout;
	assign pin.x    = x3;
	assign pin.y    = y3;
	assign pin.last = l3;

	cbf_xform #(.FRAC_BITS(FRAC_BITS)) u_xf (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q), .in_valid(v3),
		.in_pt(pin), .out_valid(out_valid), .out_pt(pout)
	);

	assign out_x    = pout.x;
	assign out_y    = pout.y;
	assign run_last = pout.last;
endmodule
`default_nettype wire

/* rtl/cbf_checker.sv */
// ----------------------------------------------------------------------------
// cbf_checker
// Port-level checks of the Bezier flattening core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_bezier_flatten_transform_core_assert.svh"
module cbf_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire        run_last,
	input wire [31:0] out_x
);
	`CBF_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_x))
	`CBF_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`CBF_ASSERT_NXT(a_last_hold, clk, arst_n, out_valid && !out_ready, $stable(run_last))
endmodule
bind cubic_bezier_flatten_transform_core cbf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .run_last(run_last), .out_x(out_x)
);
`default_nettype wire
